// File: sv/htd_pkg.sv
package htd_pkg;

	localparam int NODE_COUNT = 256;
	localparam int NODE_AW    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int CODE_W     = 10;
	localparam int ENTRY_W    = 2 * CODE_W;

	localparam logic [CODE_W-1:0] END_CODE   = CODE_W'(256);
	localparam logic [CODE_W-1:0] FIRST_NODE = CODE_W'(257);
	localparam logic [CODE_W-1:0] ROOT_RESET = CODE_W'(257);

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [NODE_AW-1:0] node_idx_t;

	typedef enum logic [1:0] {
		CMD_WRITE   = 2'd0,
		CMD_STREAM  = 2'd1,
		CMD_RESTART = 2'd2,
		CMD_UNUSED  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH
	} state_t;

	function automatic logic is_node(input code_t code);
		logic [CODE_W:0] wide;
		wide = {1'b0, code};
		return (code >= FIRST_NODE) &&
			(wide < ((CODE_W+1)'(FIRST_NODE) + (CODE_W+1)'(NODE_COUNT)));
	endfunction

	function automatic node_idx_t node_idx(input code_t code);
		code_t diff;
		diff = code - FIRST_NODE;
		return diff[NODE_AW-1:0];
	endfunction

endpackage

// File: sv/htd_ram.sv
module htd_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 256
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/huffman_tree_decoder_core.sv
// A stream byte is walked through the tree one bit at a time, one node table read per bit,
// until its eighth bit or the end marker; a flush state then hands over the final result.
// Tree writes and restarts finish on accept. No new item is taken before a byte's flush ends.
// The walk is bounded by the single registered read port of the node table.
// Reset (arst_n low, asynchronous): root and walk return to node 257, end flag and
// output valid clear; the node table holds no reset and must be written before use.
module huffman_tree_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] command,
	input  logic [7:0] node_index,
	input  logic [9:0] child_zero,
	input  logic [9:0] child_one,
	input  logic [7:0] stream_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] symbol,
	output logic       end_of_stream,
	output logic       last,
	input  logic       cfg_wr_en,
	input  logic [9:0] cfg_wr_data
);

	htd_pkg::state_t    state_q, state_d;
	htd_pkg::code_t     root_q, walk_q, walk_d, child;
	logic               ended_q;
	logic [7:0]         byte_q;
	logic [2:0]         bit_q;
	logic               pend_v_q, pend_end_q;
	logic [7:0]         pend_sym_q;
	logic               out_valid_q, out_end_q, out_last_q;
	logic [7:0]         out_sym_q;

	logic [htd_pkg::ENTRY_W-1:0] rdata;
	logic               ram_we, ram_re;
	htd_pkg::node_idx_t ram_raddr;

	logic               accept, out_free, leaf, stall;
	logic               walk_ld, restart, start_byte, bit_step, finish_end;
	logic               push, pend_ld, flush_out;

	htd_ram #(
		.WIDTH(htd_pkg::ENTRY_W),
		.DEPTH(htd_pkg::NODE_COUNT)
	) u_node_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(node_index[htd_pkg::NODE_AW-1:0]),
		.wdata({child_one, child_zero}),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	assign in_ready      = (state_q == htd_pkg::ST_IDLE);
	assign accept        = in_valid && in_ready;
	assign out_free      = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign symbol        = out_sym_q;
	assign end_of_stream = out_end_q;
	assign last          = out_last_q;

	// child reached by the current bit; a walk that is off the tree ends the stream
	always_comb begin
		if (!htd_pkg::is_node(walk_q)) begin
			child = htd_pkg::END_CODE;
		end else if (byte_q[bit_q]) begin
			child = rdata[htd_pkg::ENTRY_W-1:htd_pkg::CODE_W];
		end else begin
			child = rdata[htd_pkg::CODE_W-1:0];
		end
	end

	assign leaf  = !htd_pkg::is_node(child);
	assign stall = leaf && pend_v_q && !out_free;

	always_comb begin
		state_d    = state_q;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_raddr  = htd_pkg::node_idx(walk_q);
		walk_d     = walk_q;
		walk_ld    = 1'b0;
		restart    = 1'b0;
		start_byte = 1'b0;
		bit_step   = 1'b0;
		finish_end = 1'b0;
		push       = 1'b0;
		pend_ld    = 1'b0;
		flush_out  = 1'b0;
		unique case (state_q)
			htd_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (htd_pkg::cmd_t'(command))
						htd_pkg::CMD_WRITE: begin
							ram_we = (int'(node_index) < htd_pkg::NODE_COUNT);
						end
						htd_pkg::CMD_STREAM: begin
							if (!ended_q) begin
								// prime the read for the first bit
								ram_re     = 1'b1;
								start_byte = 1'b1;
								state_d    = htd_pkg::ST_WALK;
							end
						end
						htd_pkg::CMD_RESTART: begin
							restart = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			htd_pkg::ST_WALK: begin
				if (!stall) begin
					walk_d    = leaf ? root_q : child;
					walk_ld   = 1'b1;
					ram_re    = 1'b1;
					ram_raddr = htd_pkg::node_idx(walk_d);
					bit_step  = 1'b1;
					push      = leaf && pend_v_q;
					pend_ld   = leaf;
					if (leaf && (child >= htd_pkg::END_CODE)) begin
						finish_end = 1'b1;
						state_d    = htd_pkg::ST_FLUSH;
					end else if (bit_q == 3'd7) begin
						state_d = htd_pkg::ST_FLUSH;
					end
				end
			end
			htd_pkg::ST_FLUSH: begin
				if (!pend_v_q) begin
					state_d = htd_pkg::ST_IDLE;
				end else if (out_free) begin
					flush_out = 1'b1;
					state_d   = htd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = htd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= htd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q      <= htd_pkg::ROOT_RESET;
			walk_q      <= htd_pkg::ROOT_RESET;
			ended_q     <= 1'b0;
			bit_q       <= 3'd0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				root_q <= cfg_wr_data;
			end
			if (restart) begin
				walk_q  <= root_q;
				ended_q <= 1'b0;
			end else if (walk_ld) begin
				walk_q <= walk_d;
			end
			if (finish_end) begin
				ended_q <= 1'b1;
			end
			if (start_byte) begin
				bit_q <= 3'd0;
			end else if (bit_step) begin
				bit_q <= bit_q + 3'd1;
			end
			if (pend_ld) begin
				pend_v_q <= 1'b1;
			end else if (flush_out) begin
				pend_v_q <= 1'b0;
			end
			if (push || flush_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_byte) begin
			byte_q <= stream_byte;
		end
		if (pend_ld) begin
			pend_sym_q <= (child < htd_pkg::END_CODE) ? child[7:0] : 8'd0;
			pend_end_q <= (child >= htd_pkg::END_CODE);
		end
		// hold the newest result back until the next one shows whether it is the last
		if (push || flush_out) begin
			out_sym_q  <= pend_sym_q;
			out_end_q  <= pend_end_q;
			out_last_q <= flush_out;
		end
	end

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_end_q |-> out_last_q)
		else $error("end result not flagged as last");

	a_no_walk_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == htd_pkg::ST_WALK) |-> !ended_q)
		else $error("walk running after end marker");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == htd_pkg::ST_IDLE) |-> !pend_v_q)
		else $error("result left pending at idle");

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push || flush_out) |-> out_free)
		else $error("output register overwritten");

endmodule

// File: test/huffman_tree_decoder_core_tb.sv
`timescale 1ns / 100ps

module huffman_tree_decoder_core_tb;
	import htd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 12;

	typedef struct {
		cmd_t       cmd;
		logic [7:0] idx;
		code_t      zero;
		code_t      one;
		logic [7:0] data;
	} tree_item_t;

	typedef struct {
		logic [7:0] symbol;
		logic       eos;
		logic       last;
	} decoded_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] command = 2'd0;
	logic [7:0] node_index = 8'd0;
	logic [9:0] child_zero = 10'd0;
	logic [9:0] child_one = 10'd0;
	logic [7:0] stream_byte = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] symbol;
	logic       end_of_stream;
	logic       last;
	logic       cfg_wr_en = 1'b0;
	logic [9:0] cfg_wr_data = 10'd0;

	tree_item_t command_queue[$];
	decoded_t   symbol_queue[$];

	// shadow of the decoder
	logic [19:0] node_tbl[NODE_COUNT];
	code_t       walk_pos = FIRST_NODE;
	logic        walk_ended = 1'b0;
	code_t       root_cfg = ROOT_RESET;

	// nodes written so far, as seen by the item generator
	int  known_nodes[$];
	bit  node_known[NODE_COUNT];

	int  mismatches = 0;
	int  cycle_count = 0;
	int  gap_left = 0;
	int  stall_left = 0;
	bit  calm = 1'b0;

	huffman_tree_decoder_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.node_index(node_index),
		.child_zero(child_zero),
		.child_one(child_one),
		.stream_byte(stream_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.symbol(symbol),
		.end_of_stream(end_of_stream),
		.last(last),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic bit on_node(input code_t code);
		return int'(code) >= int'(FIRST_NODE) && int'(code) < int'(FIRST_NODE) + NODE_COUNT;
	endfunction

	// Advance the shadow decoder by one accepted item and queue the symbols it yields.
	function automatic void walk_tree(input tree_item_t it);
		code_t    child;
		code_t    offs;
		logic [19:0] entry;
		decoded_t res;
		int       found;
		found = 0;
		case (it.cmd)
			CMD_WRITE: begin
				node_tbl[it.idx] = {it.one, it.zero};
			end
			CMD_RESTART: begin
				walk_pos = root_cfg;
				walk_ended = 1'b0;
			end
			CMD_STREAM: begin
				for (int b = 0; b < 8; b++) begin
					if (!walk_ended) begin
						if (on_node(walk_pos)) begin
							offs = walk_pos - FIRST_NODE;
							entry = node_tbl[offs[7:0]];
							child = it.data[b] ? entry[19:10] : entry[9:0];
						end else begin
							child = END_CODE;
						end
						if (on_node(child)) begin
							walk_pos = child;
						end else begin
							res.symbol = (child < END_CODE) ? child[7:0] : 8'd0;
							res.eos = (child >= END_CODE);
							res.last = 1'b0;
							symbol_queue.push_back(res);
							found++;
							walk_pos = root_cfg;
							if (res.eos) begin
								walk_ended = 1'b1;
							end
						end
					end
				end
				if (found > 0) begin
					symbol_queue[symbol_queue.size() - 1].last = 1'b1;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void queue_item(input cmd_t c, input logic [7:0] idx, input code_t z,
			input code_t o, input logic [7:0] data);
		tree_item_t it;
		it.cmd = c;
		it.idx = idx;
		it.zero = z;
		it.one = o;
		it.data = data;
		command_queue.push_back(it);
		if (c == CMD_WRITE && !node_known[idx]) begin
			node_known[idx] = 1'b1;
			known_nodes.push_back(idx);
		end
	endfunction

	// Non-write items carry random payload in the unused fields.
	function automatic void queue_plain(input cmd_t c, input logic [7:0] data);
		queue_item(c, 8'($urandom_range(0, 255)), code_t'($urandom_range(0, 1023)),
			code_t'($urandom_range(0, 1023)), data);
	endfunction

	// Children that are node codes only name nodes already written, so no walk reads a blank entry.
	function automatic code_t pick_child();
		int r;
		r = $urandom_range(0, 99);
		if (r < 72)
			return code_t'($urandom_range(0, 255));
		else if (r < 94)
			return code_t'(int'(FIRST_NODE) + known_nodes[$urandom_range(0, known_nodes.size() - 1)]);
		else if (r < 97)
			return END_CODE;
		else
			return code_t'($urandom_range(int'(FIRST_NODE) + NODE_COUNT, 1023));
	endfunction

	function automatic void add_node(input logic [7:0] idx);
		code_t z;
		code_t o;
		z = pick_child();
		o = pick_child();
		queue_item(CMD_WRITE, idx, z, o, 8'($urandom_range(0, 255)));
	endfunction

	task automatic drain();
		while (command_queue.size() != 0 || in_valid || symbol_queue.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_root(input code_t v);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		root_cfg = v;
	endtask

	// driver
	always @(posedge clk) begin
		tree_item_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				it.cmd = cmd_t'(command);
				it.idx = node_index;
				it.zero = child_zero;
				it.one = child_one;
				it.data = stream_byte;
				walk_tree(it);
			end
			if (!in_valid || in_ready) begin
				if (in_valid && !calm && $urandom_range(0, 3) == 0)
					gap_left = $urandom_range(1, 7);
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (command_queue.size() > 0) begin
					it = command_queue.pop_front();
					command <= it.cmd;
					node_index <= it.idx;
					child_zero <= it.zero;
					child_one <= it.one;
					stream_byte <= it.data;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		decoded_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (symbol_queue.size() == 0) begin
					$display("%0t: unexpected symbol transfer: symbol %0d eos %0b last %0b",
						$time, symbol, end_of_stream, last);
					mismatches++;
				end else begin
					want = symbol_queue.pop_front();
					if (symbol !== want.symbol || end_of_stream !== want.eos ||
							last !== want.last) begin
						$display("%0t: expected symbol %0d eos %0b last %0b, got symbol %0d eos %0b last %0b",
							$time, want.symbol, want.eos, want.last, symbol, end_of_stream, last);
						mismatches++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!calm && $urandom_range(0, 5) == 0)
					stall_left = $urandom_range(1, 7);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int r;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// small fixed tree under the reset root
		queue_item(CMD_WRITE, 8'd255, END_CODE, 10'd1023, 8'h00);
		queue_item(CMD_WRITE, 8'd1, 10'd0, 10'd255, 8'hFF);
		queue_item(CMD_WRITE, 8'd0, 10'd258, 10'd512, 8'h00);
		queue_plain(CMD_STREAM, 8'h00);
		queue_plain(CMD_STREAM, 8'hFF);
		queue_plain(CMD_STREAM, 8'hAA);     // after the end marker: dropped
		queue_item(CMD_WRITE, 8'd3, 10'h055, 10'h0AA, 8'h00);
		queue_plain(CMD_RESTART, 8'h00);
		queue_plain(CMD_STREAM, 8'h02);
		queue_plain(CMD_STREAM, 8'h01);
		queue_plain(CMD_UNUSED, 8'h5A);
		queue_plain(CMD_RESTART, 8'h00);
		// self loop: a walk that carries over from one byte to the next
		queue_item(CMD_WRITE, 8'd2, 10'd259, 10'h080, 8'h00);
		queue_item(CMD_WRITE, 8'd0, 10'd259, 10'd260, 8'h00);
		queue_plain(CMD_STREAM, 8'h00);
		queue_plain(CMD_STREAM, 8'h01);
		queue_plain(CMD_STREAM, 8'hC3);

		set_root(10'd512);
		queue_plain(CMD_RESTART, 8'h00);
		queue_plain(CMD_STREAM, 8'h00);
		set_root(END_CODE);
		queue_plain(CMD_RESTART, 8'h00);
		queue_plain(CMD_STREAM, 8'hFF);
		set_root(10'd1023);
		queue_plain(CMD_RESTART, 8'h00);
		queue_plain(CMD_STREAM, 8'h5A);
		set_root(10'd0);
		queue_plain(CMD_RESTART, 8'h00);
		queue_plain(CMD_STREAM, 8'h00);
		queue_plain(CMD_STREAM, 8'h33);

		for (int phase = 0; phase < 6; phase++) begin
			if (phase == 0)
				set_root(FIRST_NODE);
			else
				set_root(code_t'(int'(FIRST_NODE) +
					known_nodes[$urandom_range(0, known_nodes.size() - 1)]));
			if (phase == 5)
				calm = 1'b1;
			// build some of the tree, restart, then mostly stream
			repeat (8) add_node(8'($urandom_range(0, 255)));
			queue_plain(CMD_RESTART, 8'h00);
			repeat (55) begin
				r = $urandom_range(0, 99);
				if (r < 12)
					add_node(8'($urandom_range(0, 255)));
				else if (r < 24)
					queue_plain(CMD_RESTART, 8'($urandom_range(0, 255)));
				else if (r < 27)
					queue_plain(CMD_UNUSED, 8'($urandom_range(0, 255)));
				else
					queue_plain(CMD_STREAM, 8'($urandom_range(0, 255)));
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: files.f
sv/htd_pkg.sv
sv/htd_ram.sv
sv/huffman_tree_decoder_core.sv
test/huffman_tree_decoder_core_tb.sv
